### hdl/mmks_pkg.sv
package mmks_pkg;

    localparam int KEY_SLOTS = 4096;
    localparam int ADDR_W    = $clog2(KEY_SLOTS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int WORD_W    = 32;
    localparam int KEY_W     = 64;
    localparam int SLOT_W    = 12;
    localparam int IMM_W     = 16;
    localparam int REG_W     = 5;

    localparam logic [WORD_W-1:0] OP_MOV       = 32'hD280_0000;
    localparam logic [WORD_W-1:0] OP_MOV_MASK  = 32'hFFE0_0000;
    localparam logic [WORD_W-1:0] OP_MOVK      = 32'hF280_0000;
    localparam logic [WORD_W-1:0] OP_MOVK_MASK = 32'hFF80_0000;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        logic clear;
        logic done;
        t_key key;
    } t_match;

endpackage

### hdl/mmks_if.sv
interface mmks_instr_if import mmks_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word instr_word;
    logic  new_image;

    modport source (output valid, output instr_word, output new_image, input ready);
    modport sink (input valid, input instr_word, input new_image, output ready);
endinterface

interface mmks_key_if import mmks_pkg::*; ();
    logic  valid;
    logic  ready;
    t_key  found_key;
    t_slot key_slot;

    modport source (output valid, output found_key, output key_slot, input ready);
    modport sink (input valid, input found_key, input key_slot, output ready);
endinterface

### hdl/mmks_ram.sv
module mmks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mmks_matcher.sv
module mmks_matcher import mmks_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  t_word  i_word,
    input  logic   i_new_image,
    output t_match o_match
);

    typedef enum logic [1:0] {
        ST_MOV,
        ST_K16,
        ST_K32,
        ST_K48
    } t_step;

    t_step            r_step, n_step, s;
    t_key             r_partial, n_partial, base;
    logic [REG_W-1:0] r_run, n_run, run_eff;
    logic             is_mov, is_movk, ok;
    logic [IMM_W-1:0] imm;
    logic [REG_W-1:0] rd;
    logic [1:0]       hw;
    logic [5:0]       sh;

    always_comb begin
        is_mov  = (i_word & OP_MOV_MASK) == OP_MOV;
        is_movk = !is_mov && ((i_word & OP_MOVK_MASK) == OP_MOVK);
        imm     = i_word[20:5];
        rd      = i_word[4:0];
        hw      = i_word[22:21];

        s       = i_new_image ? ST_MOV : r_step;
        base    = i_new_image ? '0 : r_partial;
        run_eff = i_new_image ? '0 : r_run;
        sh      = {2'(s), 4'b0000};
        ok      = (s == ST_MOV) ? is_mov : (is_movk && hw == 2'(s) && rd == run_eff);

        n_step    = r_step;
        n_partial = r_partial;
        n_run     = r_run;

        o_match.clear = i_take && i_new_image;
        o_match.done  = 1'b0;
        o_match.key   = base | (KEY_W'(imm) << 48);

        if (i_take) begin
            n_step    = s;
            n_partial = base;
            n_run     = run_eff;
            if (ok) begin
                unique case (s)
                    ST_MOV: begin
                        n_partial = KEY_W'(imm);
                        n_run     = rd;
                        n_step    = ST_K16;
                    end
                    ST_K16: begin
                        n_partial = base | (KEY_W'(imm) << sh);
                        n_step    = ST_K32;
                    end
                    ST_K32: begin
                        n_partial = base | (KEY_W'(imm) << sh);
                        n_step    = ST_K48;
                    end
                    ST_K48: begin
                        o_match.done = 1'b1;
                        n_partial    = '0;
                        n_step       = ST_MOV;
                    end
                    default: begin
                        n_step = ST_MOV;
                    end
                endcase
            end else if (is_mov) begin
                // broken run, word restarts as a new mov
                n_partial = KEY_W'(imm);
                n_run     = rd;
                n_step    = ST_K16;
            end else begin
                n_partial = '0;
                n_step    = ST_MOV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_MOV;
            r_partial <= '0;
            r_run     <= '0;
        end else begin
            r_step    <= n_step;
            r_partial <= n_partial;
            r_run     <= n_run;
        end
    end

endmodule

### hdl/mmks_store.sv
module mmks_store import mmks_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_match         i_match,
    output logic           o_busy,
    mmks_key_if.source     o_key
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPEND
    } t_state;

    t_state r_state;
    t_key   r_key;
    t_addr  r_addr;
    t_count r_count;
    logic   r_issue;
    logic   r_pend;
    logic   r_out_valid;
    t_key   r_out_key;
    t_slot  r_out_slot;

    t_key   rd_data;
    t_count eff_count;
    t_addr  last_addr;
    logic   rd_en;
    logic   wr_en;
    logic   out_free;
    logic   full;

    assign eff_count = i_match.clear ? t_count'(1) : r_count;
    assign last_addr = t_addr'(r_count - t_count'(1));
    assign full      = r_count == t_count'(KEY_SLOTS);
    assign out_free  = !r_out_valid || o_key.ready;
    assign rd_en     = (r_state == S_SEARCH) && r_issue;
    assign wr_en     = (r_state == S_APPEND) && out_free;
    assign o_busy    = r_state != S_IDLE;

    assign o_key.valid     = r_out_valid;
    assign o_key.found_key = r_out_key;
    assign o_key.key_slot  = r_out_slot;

    mmks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (t_addr'(r_count)),
        .i_wdata (r_key),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= t_count'(1);
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_out_valid <= 1'b1;
            end else if (o_key.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_count <= eff_count;
                    // slot zero always holds the zero key
                    if (i_match.done && i_match.key != '0) begin
                        r_key   <= i_match.key;
                        r_addr  <= t_addr'(1);
                        r_issue <= eff_count != t_count'(1);
                        r_pend  <= 1'b0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (r_pend && rd_data == r_key) begin
                        r_issue <= 1'b0;
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_pend <= r_issue;
                        if (r_issue) begin
                            if (r_addr == last_addr) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_addr <= r_addr + t_addr'(1);
                            end
                        end
                        if (!r_issue && !r_pend) begin
                            r_state <= full ? S_IDLE : S_APPEND;
                        end
                    end
                end
                S_APPEND: begin
                    if (out_free) begin
                        r_out_key   <= r_key;
                        r_out_slot  <= t_slot'(r_count);
                        r_count     <= r_count + t_count'(1);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/mov_movk_key_scanner.sv
// words transfer at one per cycle; a word that ends a run on a nonzero key stops
// input while the store is searched one slot per cycle on its single read port and
// while a key still waits in the output register
// a new key is presented after the search and append states, behind one output register
// reset is synchronous active low: match progress cleared, store holds key zero only
module mov_movk_key_scanner import mmks_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mmks_instr_if.sink    i_instr,
    mmks_key_if.source    o_key
);

    t_match match;
    logic   busy;
    logic   take;

    assign i_instr.ready = !busy;
    assign take          = i_instr.valid && !busy;

    mmks_matcher u_matcher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_word      (i_instr.instr_word),
        .i_new_image (i_instr.new_image),
        .o_match     (match)
    );

    mmks_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_match (match),
        .o_busy  (busy),
        .o_key   (o_key)
    );

endmodule

### tb/key_scan_checker.sv
`timescale 1ns / 100ps

module key_scan_checker import mmks_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mmks_instr_if i_instr,
    mmks_key_if   i_key,
    output int    o_mismatches,
    output int    o_pending
);

    typedef struct packed {
        t_key  key;
        t_slot slot;
    } t_found;

    t_found           expected_keys[$];
    bit               known_keys[t_key];
    int unsigned      keys_held;
    logic [1:0]       run_step;
    t_key             run_key;
    logic [REG_W-1:0] run_reg;
    t_found           want;

    task automatic clear_image();
        known_keys.delete();
        known_keys[t_key'(0)] = 1'b1;
        keys_held = 1;
        run_step  = '0;
        run_key   = '0;
        run_reg   = '0;
    endtask

    task automatic close_run();
        t_found hit;
        hit.key  = run_key;
        hit.slot = t_slot'(keys_held);
        run_step = '0;
        run_key  = '0;
        if (!known_keys.exists(hit.key) && keys_held < KEY_SLOTS) begin
            known_keys[hit.key] = 1'b1;
            expected_keys.push_back(hit);
            keys_held++;
        end
    endtask

    task automatic scan_word(input t_word w, input logic clear);
        logic             is_mov;
        logic             is_movk;
        logic             ok;
        logic [IMM_W-1:0] imm;
        logic [REG_W-1:0] rd;
        logic [1:0]       hw;
        logic [1:0]       s;
        if (clear) clear_image();
        is_mov  = (w & OP_MOV_MASK) == OP_MOV;
        is_movk = !is_mov && ((w & OP_MOVK_MASK) == OP_MOVK);
        imm     = w[20:5];
        rd      = w[4:0];
        hw      = w[22:21];
        // a word that breaks the run gets a second look as a new MOV
        for (int tries = 0; tries < 2; tries++) begin
            s  = run_step;
            ok = (s == 2'd0) ? is_mov : (is_movk && hw == s && rd == run_reg);
            if (ok) begin
                run_key |= t_key'(imm) << (IMM_W * s);
                if (s == 2'd0) run_reg = rd;
                if (s == 2'd3) close_run();
                else run_step = s + 2'd1;
                return;
            end
            if (s == 2'd0) return;
            run_step = '0;
            run_key  = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_image();
            expected_keys.delete();
        end else begin
            if (i_key.valid && i_key.ready) begin
                if (expected_keys.size() == 0) begin
                    $display("%0t: unexpected key transfer: expected none, actual key %h slot %0d",
                             $time, i_key.found_key, i_key.key_slot);
                    o_mismatches++;
                end else begin
                    want = expected_keys.pop_front();
                    if (i_key.found_key !== want.key) begin
                        $display("%0t: found_key expected %h actual %h",
                                 $time, want.key, i_key.found_key);
                        o_mismatches++;
                    end
                    if (i_key.key_slot !== want.slot) begin
                        $display("%0t: key_slot expected %0d actual %0d",
                                 $time, want.slot, i_key.key_slot);
                        o_mismatches++;
                    end
                end
            end
            if (i_instr.valid && i_instr.ready)
                scan_word(i_instr.instr_word, i_instr.new_image);
        end
        o_pending <= expected_keys.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mmks_pkg::*;

    localparam longint CYCLE_LIMIT     = 30_000_000;
    localparam int     WORDS_PER_PHASE = 300;
    localparam int     FILL_KEYS       = 40;
    localparam int     TAIL_CYCLES     = KEY_SLOTS + 64;
    localparam t_key   KEY_A           = 64'h0123_4567_89AB_CDEF;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    int     src_idle;
    int     snk_stall;
    int     mismatches;
    int     pending;
    longint cycles = 0;
    t_key   recent_keys[$];

    mmks_instr_if instr_ch();
    mmks_key_if   key_ch();

    mov_movk_key_scanner DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_ch),
        .o_key   (key_ch)
    );

    key_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr      (instr_ch),
        .i_key        (key_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) key_ch.ready <= 1'b0;
        else key_ch.ready <= ($urandom_range(99) >= snk_stall);
    end

    function automatic t_word mov_of(input logic [IMM_W-1:0] imm, input logic [REG_W-1:0] rd);
        return OP_MOV | {11'b0, imm, rd};
    endfunction

    function automatic t_word movk_of(input logic [IMM_W-1:0] imm, input logic [1:0] hw,
                                      input logic [REG_W-1:0] rd);
        return OP_MOVK | {9'b0, hw, imm, rd};
    endfunction

    task automatic put_word(input t_word w, input logic clear);
        while ($urandom_range(99) < src_idle) begin
            instr_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        instr_ch.valid      <= 1'b1;
        instr_ch.instr_word <= w;
        instr_ch.new_image  <= clear;
        @(posedge i_clk);
        while (!instr_ch.ready) @(posedge i_clk);
    endtask

    task automatic put_key(input t_key k, input logic [REG_W-1:0] rd, input logic clear);
        put_word(mov_of(k[15:0], rd), clear);
        put_word(movk_of(k[31:16], 2'd1, rd), 1'b0);
        put_word(movk_of(k[47:32], 2'd2, rd), 1'b0);
        put_word(movk_of(k[63:48], 2'd3, rd), 1'b0);
    endtask

    // hold the sender until every predicted key has been taken
    task automatic drain_keys();
        instr_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_words(input int count);
        int               sent;
        int               cut;
        t_key             key;
        t_word            word;
        logic [REG_W-1:0] rd;
        sent = 0;
        while (sent < count) begin
            rd = REG_W'($urandom);
            if ($urandom_range(99) < 70) begin
                case ($urandom_range(9))
                    0: key = '0;
                    1, 2: begin
                        if (recent_keys.size() != 0)
                            key = recent_keys[$urandom_range(recent_keys.size() - 1)];
                        else
                            key = {$urandom, $urandom};
                    end
                    default: key = {$urandom, $urandom};
                endcase
                cut = ($urandom_range(6) == 0) ? $urandom_range(1, 3) : 4;
                for (int k = 0; k < cut; k++) begin
                    if (k == 0) word = mov_of(key[15:0], rd);
                    else word = movk_of(key[16*k +: 16], 2'(k), rd);
                    put_word(word, $urandom_range(199) == 0);
                end
                sent += cut;
                if (cut < 4) begin
                    case ($urandom_range(3))
                        0: word = $urandom;
                        1: word = mov_of(IMM_W'($urandom), REG_W'($urandom));
                        2: word = movk_of(IMM_W'($urandom), 2'(cut) + 2'($urandom_range(1, 3)), rd);
                        default: word = movk_of(IMM_W'($urandom), 2'(cut),
                                                rd ^ REG_W'($urandom_range(1, 31)));
                    endcase
                    put_word(word, $urandom_range(199) == 0);
                    sent++;
                end else begin
                    recent_keys.push_back(key);
                    if (recent_keys.size() > 16) void'(recent_keys.pop_front());
                end
            end else begin
                case ($urandom_range(3))
                    0: word = $urandom;
                    1: word = mov_of(IMM_W'($urandom), rd);
                    2: word = movk_of(IMM_W'($urandom), 2'($urandom), rd);
                    default: word = mov_of(IMM_W'($urandom), rd) ^ (32'd1 << $urandom_range(31));
                endcase
                put_word(word, $urandom_range(199) == 0);
                sent++;
            end
        end
    endtask

    // a batch of distinct keys back to back, one repeated, then a restart on a new image
    task automatic fill_store();
        t_key key;
        for (int k = 1; k <= FILL_KEYS; k++) begin
            key = {$urandom, 19'($urandom), 13'(k)};
            put_key(key, REG_W'($urandom), k == 1);
        end
        put_key(key, REG_W'($urandom), 1'b0);
        put_key(key, REG_W'($urandom), 1'b1);
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        instr_ch.valid      <= 1'b0;
        instr_ch.instr_word <= '0;
        instr_ch.new_image  <= 1'b0;
        snk_stall           <= 0;
        src_idle = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_key(KEY_A, 5'd5, 1'b1);
        put_key(KEY_A, 5'd7, 1'b0);
        put_key('0, 5'd0, 1'b0);
        // a MOV in place of the first MOVK starts a new run
        put_word(mov_of(16'h1234, 5'd3), 1'b0);
        put_key('1, 5'd31, 1'b0);
        // wrong shift, then other register
        put_word(mov_of(16'h00AA, 5'd1), 1'b0);
        put_word(movk_of(16'h00BB, 2'd2, 5'd1), 1'b0);
        put_word(mov_of(16'h00CC, 5'd1), 1'b0);
        put_word(movk_of(16'h00DD, 2'd1, 5'd2), 1'b0);
        put_word('0, 1'b0);
        put_word('1, 1'b0);
        // unfinished run dropped by a new image
        put_word(mov_of(16'h5555, 5'd4), 1'b0);
        put_word(movk_of(16'h6666, 2'd1, 5'd4), 1'b0);
        put_word(movk_of(16'h7777, 2'd2, 5'd4), 1'b1);
        put_word(movk_of(16'h8888, 2'd3, 5'd4), 1'b0);
        put_key(KEY_A, 5'd5, 1'b1);
        drain_keys();

        random_words(WORDS_PER_PHASE);
        drain_keys();
        src_idle = 86;
        random_words(WORDS_PER_PHASE);
        drain_keys();
        src_idle = 0;
        snk_stall <= 86;
        random_words(WORDS_PER_PHASE);
        drain_keys();
        src_idle = 13;
        snk_stall <= 13;
        random_words(WORDS_PER_PHASE);
        drain_keys();
        src_idle = 0;
        snk_stall <= 0;
        fill_store();
        drain_keys();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
